/* rtl/core/dtp_pkg.sv */
// Shared constants, microcode word type and microcode program of the domino tiling counter.
package dtp_pkg;

  localparam int unsigned COUNT_W = 30;
  localparam logic [COUNT_W-1:0] TILE_MOD = 30'd1000000007;

  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Step addresses of the microcode program.
  localparam upc_t S_IDLE    = 4'd0;
  localparam upc_t S_DECODE  = 4'd1;
  localparam upc_t S_INIT    = 4'd2;
  localparam upc_t S_CELL    = 4'd3;
  localparam upc_t S_READ    = 4'd4;
  localparam upc_t S_SUM     = 4'd5;
  localparam upc_t S_WRITE   = 4'd6;
  localparam upc_t S_ADVANCE = 4'd7;
  localparam upc_t S_FREAD   = 4'd8;
  localparam upc_t S_FLATCH  = 4'd9;
  localparam upc_t S_OUT     = 4'd10;

  // Jump conditions tested by the sequencer.
  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_IN_ACC,
    J_SKIP,
    J_MASK_MORE,
    J_ROWS_DONE,
    J_OUT_FREE
  } jcond_t;

  // One control word: datapath strobes, then the sequencing fields.
  typedef struct packed {
    logic   in_ready;
    logic   decode;
    logic   init_wr;
    logic   cell_start;
    logic   rd_en;
    logic   rd_final;
    logic   sum_en;
    logic   wr_en;
    logic   cell_adv;
    logic   res_ld;
    logic   out_ld;
    jcond_t cond;
    logic   hold;
    upc_t   target;
  } uword_t;

  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t uw;
    uw = '0;
    uw.cond = J_NEVER;
    case (addr)
      S_IDLE: begin
        uw.in_ready = 1'b1;
        uw.cond     = J_IN_ACC;
        uw.hold     = 1'b1;
        uw.target   = S_DECODE;
      end
      S_DECODE: begin
        uw.decode = 1'b1;
        uw.cond   = J_SKIP;
        uw.target = S_OUT;
      end
      S_INIT: begin
        uw.init_wr = 1'b1;
        uw.cond    = J_MASK_MORE;
        uw.target  = S_INIT;
      end
      S_CELL: begin
        uw.cell_start = 1'b1;
        uw.cond       = J_ROWS_DONE;
        uw.target     = S_FREAD;
      end
      S_READ: begin
        uw.rd_en = 1'b1;
      end
      S_SUM: begin
        uw.sum_en = 1'b1;
      end
      S_WRITE: begin
        uw.wr_en  = 1'b1;
        uw.cond   = J_MASK_MORE;
        uw.target = S_READ;
      end
      S_ADVANCE: begin
        uw.cell_adv = 1'b1;
        uw.cond     = J_ALWAYS;
        uw.target   = S_CELL;
      end
      S_FREAD: begin
        uw.rd_en    = 1'b1;
        uw.rd_final = 1'b1;
      end
      S_FLATCH: begin
        uw.res_ld = 1'b1;
      end
      S_OUT: begin
        uw.out_ld = 1'b1;
        uw.cond   = J_OUT_FREE;
        uw.hold   = 1'b1;
        uw.target = S_IDLE;
      end
      default: begin
        uw.cond   = J_ALWAYS;
        uw.target = S_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

/* rtl/core/domino_tiling_profile_dp_top.sv */
// Domino tiling counter: microcoded broken-profile DP over a ping-pong count memory.
//
//  channel  | direction | tdata (low bits first)         | tuser
//  s_axis   | in        | side_a[15:0], side_b[31:16]     | -
//  m_axis   | out       | tiling_count[29:0], zero pad    | status
//
// An item runs the three-step read, add, write loop over every profile of every
// cell, with one memory write per profile. Odd areas and too-wide grids skip that
// loop and go straight to the output step. Reset returns the sequencer to idle and
// empties the output register; the count memory needs no clearing because each item
// rewrites the profiles it reads. A new item is accepted while a finished result
// still waits on m_axis, and the sequencer stalls only when it has a second result
// and the first has not been taken.
module domino_tiling_profile_dp_top #(
  parameter int unsigned MAX_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // side_a [15:0], side_b [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // tiling_count [29:0], zero [31:30]
  output logic        m_axis_tuser    // status
);
  import dtp_pkg::*;

  localparam int unsigned MW    = MAX_WIDTH;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW    = MW + 1;
  localparam int unsigned DEPTH = 1 << AW;

  // Sequencer.
  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   cond_true;

  // Dimensions and loop counters.
  logic [15:0]    a_reg;
  logic [15:0]    b_reg;
  logic [15:0]    h_reg;
  logic [15:0]    row;
  logic [WW-1:0]  w_reg;
  logic [WW-1:0]  col;
  logic [MW-1:0]  mask;
  logic           bank;

  // Decode of the request.
  logic [15:0]    min_side;
  logic [15:0]    max_side;
  logic           odd_area;
  logic           too_wide;

  // Profile addressing.
  logic [MW-1:0]  last_mask;
  logic [MW-1:0]  bit_c;
  logic [MW-1:0]  bit_c1;
  logic           has_c;
  logic           has_c1;
  logic           has_right;
  logic           col_last;
  logic           rows_done;
  logic [AW-1:0]  rd_addr_a;
  logic [AW-1:0]  rd_addr_b;

  // Count memory and arithmetic.
  logic [COUNT_W-1:0] cnt_mem [0:DEPTH-1];
  logic [COUNT_W-1:0] rd_a;
  logic [COUNT_W-1:0] rd_b;
  logic               use_b;
  logic               use_b_q;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sum_mod;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;

  // Result held until the output register is free.
  logic [COUNT_W-1:0] res_count;
  logic               res_status;
  logic [COUNT_W-1:0] out_count;
  logic               out_status;

  assign uw            = ucode_rom(upc);
  // No item is taken while reset is held.
  assign s_axis_tready = uw.in_ready & ~rst;
  assign m_axis_tdata  = {{(32 - COUNT_W){1'b0}}, out_count};
  assign m_axis_tuser  = out_status;

  assign min_side = (a_reg < b_reg) ? a_reg : b_reg;
  assign max_side = (a_reg < b_reg) ? b_reg : a_reg;
  assign odd_area = a_reg[0] & b_reg[0];
  assign too_wide = min_side > 16'(MAX_WIDTH);

  // Profiles run from zero to all w low bits set.
  assign last_mask = ~({MW{1'b1}} << w_reg);
  assign bit_c     = {{(MW - 1){1'b0}}, 1'b1} << col;
  assign bit_c1    = bit_c << 1;
  assign has_c     = |(mask & bit_c);
  assign has_c1    = |(mask & bit_c1);
  assign has_right = ({1'b0, col} + 1'b1) < {1'b0, w_reg};
  assign col_last  = ({1'b0, col} + 1'b1) == {1'b0, w_reg};
  assign rows_done = (row == h_reg) || (w_reg == '0);

  // Each target profile pulls its count from the previous cell. With the cell
  // covered it came from the profile without that bit; with the cell open it came
  // from the profile with the bit (freed from above), plus a horizontal domino
  // whose right half set the neighbouring bit.
  assign rd_addr_a = uw.rd_final ? {bank, {MW{1'b0}}}
                   : (has_c ? {bank, mask & ~bit_c} : {bank, mask | bit_c});
  assign rd_addr_b = {bank, mask & ~bit_c1};
  assign use_b     = !has_c && has_right && has_c1;

  assign sum_mod = (sum >= {1'b0, TILE_MOD}) ? COUNT_W'(sum - {1'b0, TILE_MOD})
                                             : sum[COUNT_W-1:0];

  // Start of an item seeds the empty profile with one tiling, all others with zero.
  assign mem_we  = uw.init_wr | uw.wr_en;
  assign wr_addr = uw.init_wr ? {bank, mask} : {~bank, mask};
  assign wr_data = uw.init_wr ? ((mask == '0) ? COUNT_W'(1) : '0) : sum_mod;

  always_comb begin
    case (uw.cond)
      J_NEVER:     cond_true = 1'b0;
      J_ALWAYS:    cond_true = 1'b1;
      J_IN_ACC:    cond_true = s_axis_tvalid;
      J_SKIP:      cond_true = odd_area | too_wide;
      J_MASK_MORE: cond_true = mask != last_mask;
      J_ROWS_DONE: cond_true = rows_done;
      J_OUT_FREE:  cond_true = !m_axis_tvalid || m_axis_tready;
      default:     cond_true = 1'b0;
    endcase
    if (cond_true) begin
      upc_next = uw.target;
    end else if (uw.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  // Control state: step counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc           <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (uw.out_ld && cond_true) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers, all loaded before use by the program.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_reg <= s_axis_tdata[15:0];
      b_reg <= s_axis_tdata[31:16];
    end
    if (uw.decode) begin
      w_reg      <= WW'(min_side);
      h_reg      <= max_side;
      row        <= '0;
      col        <= '0;
      bank       <= 1'b0;
      mask       <= '0;
      res_count  <= '0;
      res_status <= !odd_area && too_wide;
    end
    if (uw.init_wr || uw.wr_en) begin
      mask <= mask + 1'b1;
    end
    if (uw.cell_start) begin
      mask <= '0;
    end
    if (uw.cell_adv) begin
      bank <= ~bank;
      if (col_last) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    if (uw.rd_en) begin
      use_b_q <= use_b;
    end
    if (uw.sum_en) begin
      sum <= {1'b0, rd_a} + (use_b_q ? {1'b0, rd_b} : '0);
    end
    if (uw.res_ld) begin
      res_count  <= rd_a;
      res_status <= 1'b0;
    end
    if (uw.out_ld && cond_true) begin
      out_count  <= res_count;
      out_status <= res_status;
    end
  end

  // Two banks of profile counts: one read as the previous cell, one written.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (uw.rd_en) begin
      rd_a <= cnt_mem[rd_addr_a];
      rd_b <= cnt_mem[rd_addr_b];
    end
  end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the domino tiling counter: directed table, then random grids.
module tb_top;

  import dtp_pkg::*;

  localparam int unsigned MAX_WIDTH     = 12;
  localparam int unsigned PROFILE_DEPTH = 1 << MAX_WIDTH;

  // Status codes carried on m_axis_tuser.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_WIDE = 1'b1;

  // Cycles to keep watching the output once nothing is expected any more.
  localparam int unsigned DRAIN_CYCLES = 64;
  // Longest idle stretch the sender may insert between bursts.
  localparam int unsigned LONG_GAP_MAX = 2000;

  // One result item as the bench predicts it.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               status;
  } tiling_result_t;

  // One row of stimulus. When known is set, the result is typed into the row;
  // otherwise it comes from the predictor at the moment the item is accepted.
  typedef struct packed {
    logic [15:0]        side_a;
    logic [15:0]        side_b;
    logic               known;
    logic [COUNT_W-1:0] count;
    logic               status;
  } grid_row_t;

  localparam int DIRECTED_N = 24;

  // Directed table: odd areas (including the odd test winning over the width
  // test), too-wide grids just over and far over the limit, zero sides, width one
  // columns up to the largest even side, and a handful of small full DP runs.
  localparam grid_row_t DIRECTED [DIRECTED_N] = '{
    '{16'd1,     16'd1,     1'b1, 30'd0, STATUS_OK},
    '{16'd65535, 16'd65535, 1'b1, 30'd0, STATUS_OK},
    '{16'd13,    16'd13,    1'b1, 30'd0, STATUS_OK},
    '{16'd13,    16'd65535, 1'b1, 30'd0, STATUS_OK},
    '{16'd1,     16'd3,     1'b1, 30'd0, STATUS_OK},
    '{16'd65535, 16'd65534, 1'b1, 30'd0, STATUS_TOO_WIDE},
    '{16'd13,    16'd14,    1'b1, 30'd0, STATUS_TOO_WIDE},
    '{16'd14,    16'd13,    1'b1, 30'd0, STATUS_TOO_WIDE},
    '{16'd40000, 16'd13,    1'b1, 30'd0, STATUS_TOO_WIDE},
    '{16'd0,     16'd5,     1'b1, 30'd1, STATUS_OK},
    '{16'd0,     16'd0,     1'b1, 30'd1, STATUS_OK},
    '{16'd7,     16'd0,     1'b1, 30'd1, STATUS_OK},
    '{16'd1,     16'd2,     1'b1, 30'd1, STATUS_OK},
    '{16'd2,     16'd1,     1'b1, 30'd1, STATUS_OK},
    '{16'd12,    16'd1,     1'b1, 30'd1, STATUS_OK},
    '{16'd1,     16'd65534, 1'b1, 30'd1, STATUS_OK},
    '{16'd2,     16'd2,     1'b0, 30'd0, STATUS_OK},
    '{16'd3,     16'd2,     1'b0, 30'd0, STATUS_OK},
    '{16'd2,     16'd7,     1'b0, 30'd0, STATUS_OK},
    '{16'd3,     16'd4,     1'b0, 30'd0, STATUS_OK},
    '{16'd4,     16'd3,     1'b0, 30'd0, STATUS_OK},
    '{16'd4,     16'd4,     1'b0, 30'd0, STATUS_OK},
    '{16'd5,     16'd6,     1'b0, 30'd0, STATUS_OK},
    '{16'd8,     16'd8,     1'b0, 30'd0, STATUS_OK}
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // side_a [15:0], side_b [31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // tiling_count [29:0], zero [31:30]
  logic        m_axis_tuser;   // status

  // The bench's own copy of the two profile count vectors.
  int unsigned profile_cur [PROFILE_DEPTH];
  int unsigned profile_nxt [PROFILE_DEPTH];

  grid_row_t      grid_q[$];        // every item to be sent, in order
  tiling_result_t pending_counts[$]; // results owed by the block, oldest first

  int          fail_count;
  int          checked_count;
  int          too_wide_count;
  int          full_dp_count;
  longint      cycle_limit;

  domino_tiling_profile_dp_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Period of 4: two units high, two units low.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Adds a count into one profile of the next-cell vector, modulo the prime.
  function automatic void add_profile_count(input int unsigned idx, input int unsigned v);
    int unsigned s;
    s = profile_nxt[idx & (PROFILE_DEPTH - 1)] + v;
    if (s >= TILE_MOD) s = s - TILE_MOD;
    profile_nxt[idx & (PROFILE_DEPTH - 1)] = s;
  endfunction

  // Broken-profile DP, one cell at a time in row order. Bit c of a profile is set
  // when the cell in column c is already covered by a vertical domino from above.
  function automatic tiling_result_t predict_tiling(input logic [15:0] a,
                                                    input logic [15:0] b);
    tiling_result_t res;
    int unsigned    w;
    int unsigned    h;
    int unsigned    nmasks;
    int unsigned    r;
    int unsigned    c;
    int unsigned    m;
    int unsigned    cell_bit;
    int unsigned    v;
    res.count  = '0;
    res.status = STATUS_OK;
    // The odd area test is made before the width test.
    if (a[0] && b[0]) return res;
    w = 32'((a < b) ? a : b);
    h = 32'((a < b) ? b : a);
    if (w > MAX_WIDTH) begin
      res.status = STATUS_TOO_WIDE;
      return res;
    end
    nmasks = 1 << w;
    for (m = 0; m < PROFILE_DEPTH; m++) begin
      profile_cur[m] = 0;
      profile_nxt[m] = 0;
    end
    profile_cur[0] = 1;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        cell_bit = 1 << c;
        for (m = 0; m < nmasks; m++) profile_nxt[m] = 0;
        for (m = 0; m < nmasks; m++) begin
          v = profile_cur[m];
          if (v != 0) begin
            if ((m & cell_bit) != 0) begin
              add_profile_count(m & ~cell_bit, v);
            end else begin
              add_profile_count(m | cell_bit, v);
              if ((c + 1 < w) && ((m & (cell_bit << 1)) == 0))
                add_profile_count(m | (cell_bit << 1), v);
            end
          end
        end
        for (m = 0; m < nmasks; m++) profile_cur[m] = profile_nxt[m];
      end
    end
    res.count = profile_cur[0][COUNT_W-1:0];
    return res;
  endfunction

  // Cycle cost of one grid, as the bench estimates it for the watchdog budget.
  function automatic longint grid_cycles(input logic [15:0] a, input logic [15:0] b);
    longint w;
    longint h;
    w = longint'((a < b) ? a : b);
    h = longint'((a < b) ? b : a);
    if ((a[0] && b[0]) || w > MAX_WIDTH) return 16;
    return (longint'(1) << w) + h * w * (3 * (longint'(1) << w) + 2) + 6;
  endfunction

  // Random grids. Most are small grids that run the full DP unless their area is odd;
  // the rest are odd areas and too-wide grids over the whole field range, zero sides
  // and long single columns.
  task automatic add_random_grids(input int n);
    grid_row_t   row;
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    int          i;
    for (i = 0; i < n; i++) begin
      row  = '0;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (pick < 6) begin
          w = 6;
          h = $urandom_range(6, 8);
        end else begin
          w = $urandom_range(1, 5);
          h = $urandom_range(w, 14);
        end
        if ($urandom_range(0, 1) == 1) begin
          row.side_a = w[15:0];
          row.side_b = h[15:0];
        end else begin
          row.side_a = h[15:0];
          row.side_b = w[15:0];
        end
      end else if (pick < 80) begin
        row.side_a = 16'($urandom_range(0, 65535)) | 16'd1;
        row.side_b = 16'($urandom_range(0, 65535)) | 16'd1;
      end else if (pick < 90) begin
        row.side_a = 16'($urandom_range(MAX_WIDTH + 1, 65535));
        row.side_b = 16'($urandom_range(MAX_WIDTH + 1, 65535));
        // Keep the area even so that the width test decides.
        if (row.side_a[0] && row.side_b[0]) begin
          if ($urandom_range(0, 1) == 1) row.side_a[0] = 1'b0;
          else row.side_b[0] = 1'b0;
        end
      end else if (pick < 95) begin
        row.side_a = 16'd0;
        row.side_b = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) begin
          row.side_a = row.side_b;
          row.side_b = 16'd0;
        end
      end else begin
        row.side_a = 16'd1;
        row.side_b = 16'(2 * $urandom_range(1, 100));
      end
      grid_q.push_back(row);
    end
  endtask

  // Receiver: readiness follows a mode chosen anew at random, ranging from
  // always ready through random and fixed-pattern stalls to mostly stalled.
  initial begin : result_sink
    int unsigned mode;
    int unsigned phase;
    logic [7:0]  pattern;
    m_axis_tready = 1'b0;
    mode    = 0;
    pattern = 8'hff;
    phase   = 0;
    forever begin
      @(negedge clk);
      if (phase % 48 == 0) begin
        mode    = $urandom_range(0, 3);
        pattern = 8'($urandom_range(0, 255)) | 8'h01;
      end
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = pattern[phase % 8];
        default: m_axis_tready = ($urandom_range(0, 3) == 0);
      endcase
      phase++;
    end
  end

  // Output checker: each accepted result is compared with the oldest
  // outstanding expectation, field by field.
  always @(posedge clk) begin
    tiling_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        $error("unexpected result item: count %0d, status %0d",
               m_axis_tdata[COUNT_W-1:0], m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_counts.pop_front();
        checked_count++;
        if (m_axis_tdata[COUNT_W-1:0] !== want.count) begin
          $error("tiling_count mismatch: expected %0d, actual %0d",
                 want.count, m_axis_tdata[COUNT_W-1:0]);
          fail_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[31:COUNT_W] !== '0) begin
          $error("tdata pad mismatch: expected 0, actual %0d", m_axis_tdata[31:COUNT_W]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog. The limit is set at time zero from the stimulus list, before the
  // first clock edge.
  initial begin : watchdog
    longint cycles;
    cycles = 0;
    do begin
      @(posedge clk);
      cycles++;
    end while (cycles < cycle_limit);
    $error("run exceeded %0d cycles", cycle_limit);
    $display("tb: failure");
    $finish;
  end

  // Main sequence: build the stimulus, reset, send every item in bursts with
  // random gaps, then wait for the last result and report.
  initial begin : stimulus
    longint         budget;
    int             idx;
    int unsigned    burst_left;
    int unsigned    gap;
    grid_row_t      row;
    tiling_result_t want;

    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    fail_count     = 0;
    checked_count  = 0;
    too_wide_count = 0;
    full_dp_count  = 0;

    for (idx = 0; idx < DIRECTED_N; idx++) grid_q.push_back(DIRECTED[idx]);
    add_random_grids(76);

    // Every item at its full cost, plus the longest sender gap and a long
    // receiver stall per item, taken four times over.
    budget = 1000;
    foreach (grid_q[i])
      budget += grid_cycles(grid_q[i].side_a, grid_q[i].side_b) + LONG_GAP_MAX + 200;
    cycle_limit = 4 * budget;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    burst_left = $urandom_range(1, 8);
    for (idx = 0; idx < grid_q.size(); idx++) begin
      row = grid_q[idx];
      @(negedge clk);
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = {row.side_b, row.side_a};
      do @(posedge clk); while (!s_axis_tready);

      if (row.known) begin
        want.count  = row.count;
        want.status = row.status;
      end else begin
        want = predict_tiling(row.side_a, row.side_b);
      end
      pending_counts.push_back(want);
      if (want.status == STATUS_TOO_WIDE) too_wide_count++;
      else if (!(row.side_a[0] && row.side_b[0])) full_dp_count++;

      // End of a burst: drop valid for a short gap, now and then a long one
      // that lets the block drain and sit idle.
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, LONG_GAP_MAX)
                                          : $urandom_range(0, 4);
        if (gap > 0) begin
          @(negedge clk);
          s_axis_tvalid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;

    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d grids sent (%0d directed), %0d results checked",
             grid_q.size(), DIRECTED_N, checked_count);
    $display("summary: %0d reached the profile DP, %0d were too wide",
             full_dp_count, too_wide_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
